[hdl/cle_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cle_pkg: shared types and constants
// State codes and key codes for the console line editor with echo.
// ---------------------------------------------------------------------------
package cle_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ECHO,
    ST_CR,
    ST_LF,
    ST_BS1,
    ST_SP,
    ST_BS2
  } cle_state_t;

  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_TAB   = 8'h09;
  localparam logic [7:0] KEY_LF    = 8'h0A;
  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_LNEXT = 8'h16;
  localparam logic [7:0] KEY_DEL   = 8'h7F;
  localparam logic [7:0] KEY_BELL  = 8'h07;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_TILDE = 8'h7E;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_READ = 1'b1;

  function automatic logic is_printable(input logic [7:0] b);
    is_printable = (b >= KEY_SPACE) && (b <= KEY_TILDE);
  endfunction

endpackage
`default_nettype wire

[hdl/console_line_editor_echo_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// console_line_editor_echo_top: console line editor with terminal echo
// The first result, if any, appears in the cycle after the request is taken;
// a literal-next key or a backspace on an empty line gives none. Results come
// out one per cycle, up to 8 per request, from the echo sequencer.
// The receiver cannot stall; busy stays high until the last result is out.
// Reset (rst_n low, synchronous) empties the line and clears literal mode
// and the echo column; line bytes are undefined until written.
// ---------------------------------------------------------------------------
module console_line_editor_echo_top #(
  parameter int LINE_MAX = 125
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_opcode,
  input  wire logic [7:0] in_key_byte,
  input  wire logic [6:0] in_read_index,
  output logic            out_strobe,
  output logic            out_result_kind,
  output logic      [7:0] out_data_byte,
  output logic            out_last,
  output logic            out_line_done,
  output logic      [6:0] out_line_length
);

  import cle_pkg::*;

  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int LW = $clog2(LINE_MAX + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(LINE_MAX);

  cle_state_t    state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          lit_r, lit_nxt;
  logic [2:0]    col_r, col_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [6:0]    dlen_r, dlen_nxt;
  logic          oor_r, oor_nxt;

  logic          wr_en;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [7:0]    rd_data;
  logic          accept;
  logic          full;
  logic [7:0]    stored;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign full   = (len_r >= LEN_MAX);
  assign stored = (in_key_byte == KEY_TAB) ? KEY_SPACE : in_key_byte;

  cle_line_store #(
    .DEPTH (LINE_MAX),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(len_r)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (AW'(in_read_index)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      lit_r   <= 1'b0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      lit_r   <= lit_nxt;
      col_r   <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    cnt_r  <= cnt_nxt;
    done_r <= done_nxt;
    dlen_r <= dlen_nxt;
    oor_r  <= oor_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    lit_nxt   = lit_r;
    col_nxt   = col_r;
    byte_nxt  = byte_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    dlen_nxt  = dlen_r;
    oor_nxt   = oor_r;
    wr_en     = 1'b0;
    wr_data   = in_key_byte;
    rd_en     = 1'b0;

    out_strobe      = 1'b0;
    out_result_kind = KIND_ECHO;
    out_data_byte   = byte_r;
    out_last        = 1'b0;
    out_line_done   = 1'b0;
    out_line_length = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          done_nxt = 1'b0;
          cnt_nxt  = 4'd1;
          if (in_opcode == OP_READ) begin
            oor_nxt   = (32'(in_read_index) >= 32'(LINE_MAX));
            rd_en     = (32'(in_read_index) < 32'(LINE_MAX));
            state_nxt = ST_READ;
          end else if (lit_r) begin
            lit_nxt = 1'b0;
            if (full) begin
              byte_nxt  = KEY_BELL;
              state_nxt = ST_ECHO;
            end else begin
              wr_en   = 1'b1;
              wr_data = in_key_byte;
              len_nxt = len_r + LW'(1);
              if (in_key_byte == KEY_TAB) begin
                byte_nxt  = KEY_SPACE;
                cnt_nxt   = 4'd8 - {1'b0, col_r};
                col_nxt   = '0;
                state_nxt = ST_ECHO;
              end else if (in_key_byte == KEY_LF) begin
                col_nxt   = '0;
                state_nxt = ST_CR;
              end else begin
                byte_nxt  = in_key_byte;
                col_nxt   = col_r + 3'(is_printable(in_key_byte));
                state_nxt = ST_ECHO;
              end
            end
          end else if (in_key_byte == KEY_LF || in_key_byte == KEY_CR) begin
            done_nxt  = 1'b1;
            dlen_nxt  = 7'(len_r);
            len_nxt   = '0;
            col_nxt   = '0;
            state_nxt = ST_CR;
          end else if (in_key_byte == KEY_BS || in_key_byte == KEY_DEL) begin
            if (len_r != '0) begin
              len_nxt   = len_r - LW'(1);
              col_nxt   = col_r + 3'd1;
              state_nxt = ST_BS1;
            end
          end else if (in_key_byte == KEY_LNEXT) begin
            lit_nxt = 1'b1;
          end else if (!is_printable(stored) || full) begin
            byte_nxt  = KEY_BELL;
            state_nxt = ST_ECHO;
          end else begin
            wr_en     = 1'b1;
            wr_data   = stored;
            len_nxt   = len_r + LW'(1);
            byte_nxt  = stored;
            col_nxt   = col_r + 3'd1;
            state_nxt = ST_ECHO;
          end
        end
      end
      ST_READ: begin
        out_strobe      = 1'b1;
        out_result_kind = KIND_READ;
        out_data_byte   = oor_r ? 8'h00 : rd_data;
        out_last        = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_ECHO: begin
        out_strobe = 1'b1;
        out_last   = (cnt_r == 4'd1);
        cnt_nxt    = cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CR: begin
        out_strobe      = 1'b1;
        out_data_byte   = KEY_CR;
        out_line_done   = done_r;
        out_line_length = done_r ? dlen_r : 7'd0;
        state_nxt       = ST_LF;
      end
      ST_LF: begin
        out_strobe      = 1'b1;
        out_data_byte   = KEY_LF;
        out_last        = 1'b1;
        out_line_done   = done_r;
        out_line_length = done_r ? dlen_r : 7'd0;
        state_nxt       = ST_IDLE;
      end
      ST_BS1: begin
        out_strobe    = 1'b1;
        out_data_byte = KEY_BS;
        state_nxt     = ST_SP;
      end
      ST_SP: begin
        out_strobe    = 1'b1;
        out_data_byte = KEY_SPACE;
        state_nxt     = ST_BS2;
      end
      ST_BS2: begin
        out_strobe    = 1'b1;
        out_data_byte = KEY_BS;
        out_last      = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !busy)
    else $error("busy held after final result");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("result run broken before final result");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("line length beyond limit");

  a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == OP_READ |=>
      out_strobe && out_result_kind == KIND_READ && out_last)
    else $error("read request gave no read data");

  a_done_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_line_done |-> out_strobe && out_result_kind == KIND_ECHO)
    else $error("line end flagged off an echo result");

endmodule
`default_nettype wire

[hdl/cle_line_store.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cle_line_store: line byte memory
// One write port and one read port; read data registered.
// ---------------------------------------------------------------------------
module cle_line_store #(
  parameter int DEPTH = 125,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
